@@ sv/virtual_region_allocator_unit_macros.svh @@
// Assertion macros for the virtual region allocator.
`ifndef VIRTUAL_REGION_ALLOCATOR_UNIT_MACROS_SVH
`define VIRTUAL_REGION_ALLOCATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define VRA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vra: same-cycle check failed");
`define VRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vra: next-cycle check failed");
`else
`define VRA_ASSERT_SAME(label, clk, rst, ante, cons)
`define VRA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ sv/vra_pkg.sv @@
package vra_pkg;

  localparam int MAX_REGIONS_DEF = 16;
  localparam int PAGE_BYTES_DEF  = 4096;

  localparam logic [20:0] COUNT_MAX = 21'h1FFFFF;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] request_bytes;
    logic [31:0] target_address;
  } vra_req_t;

  typedef struct packed {
    logic [31:0] region_start;
    logic        is_legal;
    logic [1:0]  status;
    logic [31:0] freed_first_page;
    logic [20:0] freed_page_count;
  } vra_rsp_t;

  // word moving down the slot chain
  // addr: region start for allocate, target address otherwise
  // bytes: request size for allocate, size of the freed slot for release
  typedef struct packed {
    logic        valid;
    logic [1:0]  op;
    logic [31:0] bytes;
    logic [31:0] addr;
    logic        hit;
  } vra_tok_t;

endpackage

@@ sv/vra_cell.sv @@
module vra_cell
  import vra_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  vra_tok_t tin,
  output vra_tok_t tout
);

  logic        slot_live;
  logic [31:0] slot_start;
  logic [31:0] slot_bytes;

  logic        claim;
  logic        drop;
  logic        covered;
  logic [32:0] slot_lim;
  vra_tok_t    tout_next;

  always_comb begin
    slot_lim = {1'b0, slot_start} + {1'b0, slot_bytes};
    claim = tin.valid && (tin.op == OP_ALLOC) && !tin.hit && !slot_live;
    drop  = tin.valid && (tin.op == OP_RELEASE) && !tin.hit && slot_live &&
            (slot_start == tin.addr);
    covered = tin.valid && (tin.op == OP_CHECK) && slot_live &&
              (tin.addr >= slot_start) && ({1'b0, tin.addr} < slot_lim);
    tout_next = tin;
    if (claim || drop || covered) begin
      tout_next.hit = 1'b1;
    end
    if (drop) begin
      tout_next.bytes = slot_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout <= '0;
    end else begin
      tout <= tout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_live <= 1'b0;
    end else if (claim) begin
      slot_live <= 1'b1;
    end else if (drop) begin
      slot_live <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      slot_start <= tin.addr;
      slot_bytes <= tin.bytes;
    end
  end

endmodule

@@ sv/virtual_region_allocator_unit.sv @@
// An accepted start passes the head register, each slot cell, the finish register
// and the done register. One operation in flight; the next start is taken in
// the done cycle, so no new operation is taken while one is still in flight.
// Results come as a one-cycle done strobe; the receiver cannot stall them.
// Synchronous reset: all slots free, used bytes = one page, pool_base = 0.
`include "virtual_region_allocator_unit_macros.svh"

module virtual_region_allocator_unit
  import vra_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  vra_req_t    req,
  output logic        done,
  output vra_rsp_t    rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  // PAGE_BYTES is a power of two
  localparam int          PAGE_LG = $clog2(PAGE_BYTES);
  localparam logic [32:0] PAGE_M1 = 33'(PAGE_BYTES - 1);
  localparam logic [31:0] PAGE_32 = 32'(PAGE_BYTES);

  logic [31:0] pool_base;
  logic [31:0] used_bytes;
  logic [31:0] used_bytes_next;

  vra_tok_t tok [MAX_REGIONS+1];
  vra_tok_t head_next;
  logic     accept;

  logic        fin_valid;
  logic [1:0]  fin_op;
  logic        fin_hit;
  logic [31:0] fin_addr;
  logic [32:0] fin_pages;
  logic [32:0] fin_round;

  logic [32:0] tail_sum;
  logic [32:0] tail_pages;
  logic [31:0] end_addr;
  logic [31:0] top_addr;
  vra_rsp_t    rsp_next;

  assign accept    = start && !busy;
  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pool_base <= cfg_data;
    end
  end

  always_comb begin
    head_next       = '0;
    head_next.valid = accept;
    head_next.op    = req.operation;
    head_next.bytes = req.request_bytes;
    head_next.addr  = req.target_address;
    if (req.operation == OP_ALLOC) begin
      head_next.addr = pool_base + used_bytes;
    end
    head_next.hit = (req.operation == OP_CHECK) && (req.target_address == pool_base);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0] <= '0;
    end else begin
      tok[0] <= head_next;
    end
  end

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_chain
    vra_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .tin  (tok[i]),
      .tout (tok[i+1])
    );
  end

  always_comb begin
    tail_sum   = {1'b0, tok[MAX_REGIONS].bytes} + PAGE_M1;
    tail_pages = tail_sum >> PAGE_LG;
  end

  always_ff @(posedge clk) begin
    fin_op    <= tok[MAX_REGIONS].op;
    fin_hit   <= tok[MAX_REGIONS].hit;
    fin_addr  <= tok[MAX_REGIONS].addr;
    fin_pages <= tail_pages;
    fin_round <= tail_pages << PAGE_LG;
    if (rst) begin
      fin_valid <= 1'b0;
    end else begin
      fin_valid <= tok[MAX_REGIONS].valid;
    end
  end

  always_comb begin
    end_addr        = fin_addr + fin_round[31:0];
    top_addr        = pool_base + used_bytes;
    rsp_next        = '0;
    used_bytes_next = used_bytes;
    case (fin_op)
      OP_ALLOC: begin
        if (fin_hit) begin
          rsp_next.region_start = fin_addr;
          used_bytes_next       = used_bytes + fin_round[31:0];
        end else begin
          rsp_next.status = ST_FULL;
        end
      end
      OP_RELEASE: begin
        if (fin_hit) begin
          rsp_next.freed_first_page = fin_addr;
          rsp_next.freed_page_count = (fin_pages > 33'(COUNT_MAX)) ? COUNT_MAX
                                                                   : fin_pages[20:0];
          if (end_addr == top_addr) begin
            used_bytes_next = used_bytes - fin_round[31:0];
          end
        end else begin
          rsp_next.status = ST_MISS;
        end
      end
      OP_CHECK: begin
        rsp_next.is_legal = fin_hit;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin_valid) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_bytes <= PAGE_32;
      busy       <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= fin_valid;
      if (fin_valid) begin
        used_bytes <= used_bytes_next;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (fin_valid) begin
        busy <= 1'b0;
      end
    end
  end

  `VRA_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `VRA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy && !done)
  `VRA_ASSERT_SAME(a_tail_busy, clk, rst, tok[MAX_REGIONS].valid || fin_valid, busy)
  `VRA_ASSERT_SAME(a_used_aligned, clk, rst, 1'b1, used_bytes[PAGE_LG-1:0] == '0)

endmodule
